// ----- rtl/skl_pkg.sv -----
`default_nettype none
// ============================================================================
// skl_pkg
// Shared types and constants of the sorted key list: widths, opcodes,
// status codes, controller states and the command broadcast to the cells.
// ============================================================================
package skl_pkg;

    // Storage geometry.
    localparam int unsigned DEPTH     = 16;
    localparam int unsigned KEY_WIDTH = 32;
    localparam int unsigned IDX_W     = $clog2(DEPTH);
    localparam int unsigned CNT_W     = $clog2(DEPTH + 1);

    // Field widths of the transactions.
    localparam int unsigned OPCODE_W = 3;
    localparam int unsigned VALUE_W  = 32;
    localparam int unsigned POS_W    = 5;
    localparam int unsigned STATUS_W = 3;
    localparam int unsigned COUNT_W  = 5;

    typedef logic [KEY_WIDTH-1:0] t_key;

    typedef enum logic [OPCODE_W-1:0] {
        OP_INSERT    = 3'd0,
        OP_POP_FRONT = 3'd1,
        OP_POP_BACK  = 3'd2,
        OP_FIND      = 3'd3,
        OP_REMOVE_AT = 3'd4,
        OP_READ_AT   = 3'd5
    } t_opcode;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK        = 3'd0,
        STAT_NOT_FOUND = 3'd1,
        STAT_FULL      = 3'd2,
        STAT_EMPTY     = 3'd3,
        STAT_BAD_POS   = 3'd4
    } t_status;

    typedef enum logic {
        ST_IDLE   = 1'b0,
        ST_COMMIT = 1'b1
    } t_state;

    typedef enum logic [1:0] {
        SH_HOLD   = 2'd0,
        SH_INSERT = 2'd1,
        SH_REMOVE = 2'd2
    } t_shift;

    typedef struct packed {
        logic [OPCODE_W-1:0] opcode;
        logic [VALUE_W-1:0]  key;
        logic [POS_W-1:0]    position;
        logic [POS_W-1:0]    range_end;
    } t_req;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [VALUE_W-1:0]  value;
        logic [POS_W-1:0]    index;
        logic [COUNT_W-1:0]  count;
    } t_rsp;

    // Command that the controller broadcasts along the cell row.
    typedef struct packed {
        t_shift           kind;
        logic [IDX_W-1:0] idx;
        t_key             key;
    } t_cell_cmd;

endpackage
`default_nettype wire

// ----- rtl/skl_stream_if.sv -----
`default_nettype none
// ============================================================================
// skl_stream_if
// Valid/ready channel carrying one payload per transaction.
// ============================================================================
interface skl_stream_if #(
    parameter type t_payload = logic
) ();
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

// ----- rtl/skl_cell.sv -----
`default_nettype none
// ============================================================================
// skl_cell
// One slot of the sorted row: holds a key, compares it with the incoming
// key, and takes its own, the new, or a neighbor's key on each command.
// ============================================================================
module skl_cell (
    input  wire logic                          i_clk,
    input  wire logic [skl_pkg::IDX_W-1:0]     i_self,
    input  wire logic                          i_desc,
    input  wire skl_pkg::t_key                 i_cmp_key,
    input  wire skl_pkg::t_cell_cmd            i_cmd,
    input  wire skl_pkg::t_key                 i_left,
    input  wire skl_pkg::t_key                 i_right,
    output logic                               o_ge,
    output logic                               o_eq,
    output skl_pkg::t_key                      o_key
);

    skl_pkg::t_key r_key;
    skl_pkg::t_key n_key;

    // Not smaller in the current order.
    assign o_ge  = i_desc ? (r_key <= i_cmp_key) : (r_key >= i_cmp_key);
    assign o_eq  = (r_key == i_cmp_key);
    assign o_key = r_key;

    always_comb begin
        n_key = r_key;
        case (i_cmd.kind)
            skl_pkg::SH_INSERT: begin
                if (i_self == i_cmd.idx) begin
                    n_key = i_cmd.key;
                end else if (i_self > i_cmd.idx) begin
                    n_key = i_left;
                end
            end
            skl_pkg::SH_REMOVE: begin
                if (i_self >= i_cmd.idx) begin
                    n_key = i_right;
                end
            end
            default: begin
                n_key = r_key;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_key <= n_key;
    end

endmodule
`default_nettype wire

// ----- rtl/skl_ctrl.sv -----
`default_nettype none
// ============================================================================
// skl_ctrl
// Sequencer of the sorted key list: captures a request with the row's
// compare flags, then resolves positions, updates the count, drives the
// cell command and loads the response register.
// ============================================================================
module skl_ctrl (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    skl_stream_if.sink                                 i_req,
    skl_stream_if.source                               o_rsp,
    input  wire skl_pkg::t_key [skl_pkg::DEPTH-1:0]    i_keys,
    input  wire logic [skl_pkg::DEPTH-1:0]             i_ge,
    input  wire logic [skl_pkg::DEPTH-1:0]             i_eq,
    output skl_pkg::t_cell_cmd                         o_cmd
);

    localparam int unsigned DEPTH = skl_pkg::DEPTH;
    localparam int unsigned IDX_W = skl_pkg::IDX_W;
    localparam int unsigned CNT_W = skl_pkg::CNT_W;
    localparam int unsigned POS_W = skl_pkg::POS_W;

    skl_pkg::t_state r_state;
    skl_pkg::t_state n_state;
    skl_pkg::t_req   r_req;
    logic [DEPTH-1:0] r_ge;
    logic [DEPTH-1:0] r_eq;
    skl_pkg::t_key   r_rd_val;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic             r_out_valid;
    skl_pkg::t_rsp   r_rsp;
    skl_pkg::t_rsp   n_rsp;

    logic             in_ready;
    logic             accept;
    logic             commit;
    logic [IDX_W-1:0] rd_addr;
    logic [CNT_W-1:0] ins_idx;
    logic [POS_W-1:0] fnd_idx;
    logic             fnd_hit;
    logic             fnd_eq;
    logic [CNT_W-1:0] req_pos;

    assign accept        = i_req.valid && in_ready;
    assign i_req.ready   = in_ready;
    assign o_rsp.valid   = r_out_valid;
    assign o_rsp.payload = r_rsp;

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            skl_pkg::ST_IDLE: begin
                if (i_req.valid) begin
                    n_state = skl_pkg::ST_COMMIT;
                end
            end
            skl_pkg::ST_COMMIT: begin
                if (!r_out_valid || o_rsp.ready) begin
                    n_state = skl_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = skl_pkg::ST_IDLE;
            end
        endcase
    end

    // State outputs.
    always_comb begin
        in_ready = 1'b0;
        commit   = 1'b0;
        unique case (r_state)
            skl_pkg::ST_IDLE: begin
                in_ready = 1'b1;
            end
            skl_pkg::ST_COMMIT: begin
                commit = !r_out_valid || o_rsp.ready;
            end
            default: begin
                in_ready = 1'b0;
            end
        endcase
    end

    // Single read port on the row, addressed from the incoming request.
    always_comb begin
        if (i_req.payload.opcode == skl_pkg::OP_POP_FRONT) begin
            rd_addr = '0;
        end else if (i_req.payload.opcode == skl_pkg::OP_POP_BACK) begin
            rd_addr = IDX_W'(r_count - CNT_W'(1));
        end else begin
            rd_addr = i_req.payload.position[IDX_W-1:0];
        end
    end

    // First not-smaller entry below the count, and first within the find range.
    always_comb begin
        ins_idx = r_count;
        fnd_idx = r_req.range_end;
        fnd_hit = 1'b0;
        fnd_eq  = 1'b0;
        for (int i = DEPTH - 1; i >= 0; i--) begin
            if (r_ge[i] && (CNT_W'(i) < r_count)) begin
                ins_idx = CNT_W'(i);
            end
            if (r_ge[i] && (POS_W'(i) >= r_req.position) &&
                (POS_W'(i) < r_req.range_end)) begin
                fnd_idx = POS_W'(i);
                fnd_hit = 1'b1;
                fnd_eq  = r_eq[i];
            end
        end
    end

    assign req_pos = CNT_W'(r_req.position);

    // Resolution of the captured request.
    always_comb begin
        n_count      = r_count;
        n_rsp.status = skl_pkg::STAT_OK;
        n_rsp.value  = '0;
        n_rsp.index  = '0;
        o_cmd.kind   = skl_pkg::SH_HOLD;
        o_cmd.idx    = '0;
        o_cmd.key    = r_req.key[skl_pkg::KEY_WIDTH-1:0];
        unique case (r_req.opcode) inside
            skl_pkg::OP_INSERT: begin
                if (r_count >= CNT_W'(DEPTH)) begin
                    n_rsp.status = skl_pkg::STAT_FULL;
                end else begin
                    n_count      = r_count + CNT_W'(1);
                    n_rsp.value  = skl_pkg::VALUE_W'(o_cmd.key);
                    n_rsp.index  = POS_W'(ins_idx);
                    o_cmd.kind   = skl_pkg::SH_INSERT;
                    o_cmd.idx    = IDX_W'(ins_idx);
                end
            end
            skl_pkg::OP_POP_FRONT: begin
                if (r_count == '0) begin
                    n_rsp.status = skl_pkg::STAT_EMPTY;
                end else begin
                    n_count      = r_count - CNT_W'(1);
                    n_rsp.value  = skl_pkg::VALUE_W'(r_rd_val);
                    o_cmd.kind   = skl_pkg::SH_REMOVE;
                end
            end
            skl_pkg::OP_POP_BACK: begin
                if (r_count == '0) begin
                    n_rsp.status = skl_pkg::STAT_EMPTY;
                end else begin
                    n_count      = r_count - CNT_W'(1);
                    n_rsp.value  = skl_pkg::VALUE_W'(r_rd_val);
                    n_rsp.index  = POS_W'(r_count - CNT_W'(1));
                end
            end
            skl_pkg::OP_FIND: begin
                if ((r_req.position > r_req.range_end) ||
                    (r_req.range_end > POS_W'(r_count))) begin
                    n_rsp.status = skl_pkg::STAT_BAD_POS;
                end else if (fnd_hit && fnd_eq) begin
                    n_rsp.value  = r_req.key;
                    n_rsp.index  = fnd_idx;
                end else begin
                    n_rsp.status = skl_pkg::STAT_NOT_FOUND;
                    n_rsp.index  = r_req.range_end;
                end
            end
            skl_pkg::OP_REMOVE_AT, skl_pkg::OP_READ_AT: begin
                if (r_count == '0) begin
                    n_rsp.status = skl_pkg::STAT_EMPTY;
                end else if ((r_req.position >= POS_W'(r_count)) ||
                             (req_pos >= r_count)) begin
                    n_rsp.status = skl_pkg::STAT_BAD_POS;
                end else begin
                    n_rsp.value  = skl_pkg::VALUE_W'(r_rd_val);
                    n_rsp.index  = r_req.position;
                    if (r_req.opcode == skl_pkg::OP_REMOVE_AT) begin
                        n_count    = r_count - CNT_W'(1);
                        o_cmd.kind = skl_pkg::SH_REMOVE;
                        o_cmd.idx  = IDX_W'(r_req.position);
                    end
                end
            end
            default: begin
                n_rsp.status = skl_pkg::STAT_OK;
            end
        endcase
        n_rsp.count = skl_pkg::COUNT_W'(n_count);
        if (!commit) begin
            o_cmd.kind = skl_pkg::SH_HOLD;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= skl_pkg::ST_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (commit) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_req    <= i_req.payload;
            r_ge     <= i_ge;
            r_eq     <= i_eq;
            r_rd_val <= i_keys[rd_addr];
        end
        if (commit) begin
            r_rsp <= n_rsp;
        end
    end

endmodule
`default_nettype wire

// ----- rtl/sorted_key_list.sv -----
`default_nettype none
// ============================================================================
// sorted_key_list
// Sorted list of up to sixteen 32-bit keys with insert, pops, positional
// read and remove, and range find, built as a row of shifting cells.
// ============================================================================
// Each request transaction passes through the idle and commit states: in
// the cycle it is accepted every cell compares its key against the request
// key and the flags are captured together with one read of the row; in the
// commit state, once the response register is free, the controller picks
// the first not-smaller position, shifts the row one place right (insert)
// or left (pop front, remove) and loads the response register. The
// compare-then-commit loop takes one request at a time. A response waits in its own
// register, so a new request is accepted while the previous response is
// still pending; only a second response arriving on a stalled output holds
// the block in its commit cycle. Insert places a key ahead of equal keys;
// find answers with the range end when the first not-smaller key in the
// range differs from the search key. Every response carries the count after
// the operation. The order register (i_cfg_wdata, 0 ascending, 1 descending)
// is written whenever i_cfg_we is high and must only change while the
// block is idle. Stored keys have no reset value; after reset the count is
// zero and the block is ready at once.
// ============================================================================
module sorted_key_list (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    skl_stream_if.sink   i_req,
    skl_stream_if.source o_rsp,
    input  wire logic  i_cfg_we,
    input  wire logic  i_cfg_wdata
);

    localparam int unsigned DEPTH = skl_pkg::DEPTH;
    localparam int unsigned IDX_W = skl_pkg::IDX_W;

    logic                              r_desc;
    skl_pkg::t_key [DEPTH-1:0]         keys;
    logic [DEPTH-1:0]                  ge;
    logic [DEPTH-1:0]                  eq;
    skl_pkg::t_cell_cmd                cmd;
    skl_pkg::t_key                     cmp_key;

    // Order register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_desc <= 1'b0;
        end else if (i_cfg_we) begin
            r_desc <= i_cfg_wdata;
        end
    end

    assign cmp_key = i_req.payload.key[skl_pkg::KEY_WIDTH-1:0];

    // The row of cells; the ends see their own key as the missing neighbor.
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        skl_pkg::t_key left_key;
        skl_pkg::t_key right_key;

        if (g == 0) begin : g_first
            assign left_key = keys[g];
        end else begin : g_mid_l
            assign left_key = keys[g-1];
        end

        if (g == DEPTH - 1) begin : g_last
            assign right_key = keys[g];
        end else begin : g_mid_r
            assign right_key = keys[g+1];
        end

        skl_cell u_cell (
            .i_clk     (i_clk),
            .i_self    (IDX_W'(g)),
            .i_desc    (r_desc),
            .i_cmp_key (cmp_key),
            .i_cmd     (cmd),
            .i_left    (left_key),
            .i_right   (right_key),
            .o_ge      (ge[g]),
            .o_eq      (eq[g]),
            .o_key     (keys[g])
        );
    end

    skl_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .o_rsp   (o_rsp),
        .i_keys  (keys),
        .i_ge    (ge),
        .i_eq    (eq),
        .o_cmd   (cmd)
    );

endmodule
`default_nettype wire

// ----- bench/sorted_key_list_test.sv -----
`default_nettype none
// ============================================================================
// sorted_key_list_test
// Self-checking bench for the sorted key list with a scoreboard.
// ============================================================================
// A short table of hand-picked requests runs first: pops, reads and removes
// on an empty list, finds with bad ranges, inserts of the extreme keys and
// of equal keys, and finds that hit and miss. Rows whose answer is obvious
// carry it in the table. All other requests are scored against a behavioral
// copy of the list kept here. Random phases follow, in both sort orders,
// with random gaps on the request side and random stalls on the response
// side. They include a burst with no gaps, a long response stall that backs
// the block up into its request port, and insert-heavy and remove-heavy
// mixes so that the list runs full and empty many times.
// ============================================================================
module sorted_key_list_test;

    localparam int DEPTH   = skl_pkg::DEPTH;
    localparam int POS_W   = skl_pkg::POS_W;
    localparam int COUNT_W = skl_pkg::COUNT_W;

    // One row of stimulus. When has_answer is set, want is the response
    // expected from the block; otherwise the behavioral list decides.
    typedef struct packed {
        skl_pkg::t_req req;
        logic          has_answer;
        skl_pkg::t_rsp want;
    } t_stim_row;

    localparam int N_TABLE_ROWS = 23;
    localparam int MAX_GAP      = 6;
    localparam int DRAIN_LIMIT  = 5000;

    localparam skl_pkg::t_key EXTREME_KEYS [4] = '{32'h0000_0000, 32'hFFFF_FFFF,
                                                   32'h8000_0000, 32'h7FFF_FFFF};
    localparam skl_pkg::t_opcode NON_INSERT_OPS [5] = '{skl_pkg::OP_POP_FRONT,
                                                        skl_pkg::OP_POP_BACK,
                                                        skl_pkg::OP_FIND,
                                                        skl_pkg::OP_REMOVE_AT,
                                                        skl_pkg::OP_READ_AT};

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic i_cfg_wdata;

    skl_stream_if #(.t_payload(skl_pkg::t_req)) req_if ();
    skl_stream_if #(.t_payload(skl_pkg::t_rsp)) rsp_if ();

    sorted_key_list uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (req_if),
        .o_rsp       (rsp_if),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    // Behavioral copy of the list contents and of the order register.
    skl_pkg::t_key key_list [DEPTH];
    int   key_count  = 0;
    logic order_desc = 1'b0;

    t_stim_row     offered_rows [$];   // one per request transaction, in order
    skl_pkg::t_rsp awaited_rsps [$];   // responses still owed by the block
    int        error_count       = 0;
    logic      no_gaps           = 1'b0;
    int        sink_hold_cycles  = 0;

    t_stim_row table_rows [N_TABLE_ROWS];

    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // Behavioral list
    // ------------------------------------------------------------------------

    // First position in [from, upto) whose key is not below k in the current
    // order, or upto when there is none.
    function automatic int first_not_below(int from, int upto, skl_pkg::t_key k);
        for (int i = from; i < upto && i < DEPTH; i++) begin
            if (order_desc ? (key_list[i] <= k) : (key_list[i] >= k))
                return i;
        end
        return upto;
    endfunction

    function automatic void close_gap(int slot);
        for (int i = slot; i + 1 < key_count; i++)
            key_list[i] = key_list[i + 1];
        key_count--;
    endfunction

    // Applies one request to the list and returns the response it causes.
    function automatic skl_pkg::t_rsp apply_request(skl_pkg::t_req r);
        skl_pkg::t_rsp rsp;
        int   slot;
        int   pos;
        int   lim;
        rsp = '0;
        pos = int'(r.position);
        lim = int'(r.range_end);
        rsp.status = skl_pkg::STAT_OK;
        case (r.opcode) inside
            skl_pkg::OP_INSERT: begin
                if (key_count >= DEPTH) begin
                    rsp.status = skl_pkg::STAT_FULL;
                end else begin
                    slot = first_not_below(0, key_count, r.key);
                    for (int i = key_count; i > slot; i--)
                        key_list[i] = key_list[i - 1];
                    key_list[slot] = r.key;
                    key_count++;
                    rsp.value = r.key;
                    rsp.index = POS_W'(slot);
                end
            end
            skl_pkg::OP_POP_FRONT: begin
                if (key_count == 0) begin
                    rsp.status = skl_pkg::STAT_EMPTY;
                end else begin
                    rsp.value = key_list[0];
                    close_gap(0);
                end
            end
            skl_pkg::OP_POP_BACK: begin
                if (key_count == 0) begin
                    rsp.status = skl_pkg::STAT_EMPTY;
                end else begin
                    rsp.index = POS_W'(key_count - 1);
                    rsp.value = key_list[key_count - 1];
                    key_count--;
                end
            end
            skl_pkg::OP_FIND: begin
                if (pos > lim || lim > key_count) begin
                    rsp.status = skl_pkg::STAT_BAD_POS;
                end else begin
                    slot = first_not_below(pos, lim, r.key);
                    if (slot < lim && key_list[slot] == r.key) begin
                        rsp.value = r.key;
                        rsp.index = POS_W'(slot);
                    end else begin
                        rsp.status = skl_pkg::STAT_NOT_FOUND;
                        rsp.index  = POS_W'(lim);
                    end
                end
            end
            skl_pkg::OP_REMOVE_AT, skl_pkg::OP_READ_AT: begin
                if (key_count == 0) begin
                    rsp.status = skl_pkg::STAT_EMPTY;
                end else if (pos >= key_count) begin
                    rsp.status = skl_pkg::STAT_BAD_POS;
                end else begin
                    rsp.value = key_list[pos];
                    rsp.index = POS_W'(pos);
                    if (r.opcode == skl_pkg::OP_REMOVE_AT)
                        close_gap(pos);
                end
            end
            default: ;
        endcase
        rsp.count = COUNT_W'(key_count);
        return rsp;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus construction
    // ------------------------------------------------------------------------

    function automatic skl_pkg::t_req req_of(skl_pkg::t_opcode op, skl_pkg::t_key k,
                                             int pos, int lim);
        skl_pkg::t_req r;
        r.opcode    = op;
        r.key       = k;
        r.position  = POS_W'(pos);
        r.range_end = POS_W'(lim);
        return r;
    endfunction

    function automatic skl_pkg::t_rsp rsp_of(skl_pkg::t_status st, skl_pkg::t_key v,
                                             int idx, int cnt);
        skl_pkg::t_rsp r;
        r.status = st;
        r.value  = v;
        r.index  = POS_W'(idx);
        r.count  = COUNT_W'(cnt);
        return r;
    endfunction

    // Small keys collide often, which exercises equal-key ordering and find
    // hits; keys already stored make finds hit as well.
    function automatic skl_pkg::t_key random_key();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 35)
            return skl_pkg::t_key'($urandom_range(0, 7));
        if (sel < 50)
            return EXTREME_KEYS[$urandom_range(0, 3)];
        if (sel < 75 && key_count > 0)
            return key_list[$urandom_range(0, key_count - 1)];
        return skl_pkg::t_key'($urandom);
    endfunction

    // Mostly well-formed positions and ranges; one request in ten gets a
    // position and range end drawn from 0 to DEPTH instead.
    function automatic t_stim_row random_row(int insert_pct);
        t_stim_row row;
        row = '0;
        if ($urandom_range(0, 99) < insert_pct)
            row.req.opcode = skl_pkg::OP_INSERT;
        else
            row.req.opcode = NON_INSERT_OPS[$urandom_range(0, 4)];
        row.req.key = random_key();
        if ($urandom_range(0, 9) == 0) begin
            row.req.position  = POS_W'($urandom_range(0, DEPTH));
            row.req.range_end = POS_W'($urandom_range(0, DEPTH));
        end else begin
            if (row.req.opcode == skl_pkg::OP_FIND)
                row.req.position = POS_W'($urandom_range(0, key_count));
            else if (key_count > 0)
                row.req.position = POS_W'($urandom_range(0, key_count - 1));
            else
                row.req.position = '0;
            row.req.range_end = POS_W'($urandom_range(int'(row.req.position),
                                                      key_count));
        end
        return row;
    endfunction

    // ------------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------------

    // Offers one request after a random gap and returns at the falling edge
    // after its transaction. Entered at a falling edge.
    task automatic offer(t_stim_row row);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, MAX_GAP);
        offered_rows.push_back(row);
        if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        req_if.valid   <= 1'b1;
        req_if.payload <= row.req;
        do @(posedge i_clk); while (!req_if.ready);
        @(negedge i_clk);
    endtask

    task automatic random_phase(int n_items, int insert_pct);
        repeat (n_items) offer(random_row(insert_pct));
    endtask

    // Holds off new requests until every owed response has come back.
    task automatic wait_until_drained();
        int waited;
        waited = 0;
        req_if.valid <= 1'b0;
        while (awaited_rsps.size() != 0 && waited < DRAIN_LIMIT) begin
            @(negedge i_clk);
            waited++;
        end
        if (awaited_rsps.size() != 0) begin
            $error("%0d responses never arrived", awaited_rsps.size());
            error_count++;
            awaited_rsps.delete();
        end
        repeat (4) @(negedge i_clk);
    endtask

    // Only called while the block is idle.
    task automatic write_order(logic desc);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= desc;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        order_desc   = desc;
    endtask

    // ------------------------------------------------------------------------
    // Response side: a random stall before each response, plus a long hold
    // when the stimulus asks for one.
    // ------------------------------------------------------------------------
    initial begin
        int stall;
        rsp_if.ready = 1'b0;
        wait (i_rst_n === 1'b1);
        @(negedge i_clk);
        forever begin
            stall = no_gaps ? 0 : $urandom_range(0, MAX_GAP);
            if (sink_hold_cycles > 0) begin
                stall += sink_hold_cycles;
                sink_hold_cycles = 0;
            end
            if (stall > 0) begin
                rsp_if.ready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            rsp_if.ready <= 1'b1;
            do @(posedge i_clk); while (rsp_if.valid !== 1'b1);
            @(negedge i_clk);
        end
    end

    // ------------------------------------------------------------------------
    // Scoreboard: responses are checked before the request of the same edge
    // is applied, since a response never belongs to a request taken at the
    // same edge.
    // ------------------------------------------------------------------------
    skl_pkg::t_rsp seen_rsp;
    skl_pkg::t_rsp owed_rsp;
    skl_pkg::t_rsp model_rsp;
    t_stim_row     taken_row;

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (rsp_if.valid && rsp_if.ready) begin
                seen_rsp = rsp_if.payload;
                if (awaited_rsps.size() == 0) begin
                    $error("response transaction with none expected");
                    error_count++;
                end else begin
                    owed_rsp = awaited_rsps.pop_front();
                    if (seen_rsp.status !== owed_rsp.status) begin
                        $error("status: expected %0d, got %0d",
                               owed_rsp.status, seen_rsp.status);
                        error_count++;
                    end
                    if (seen_rsp.value !== owed_rsp.value) begin
                        $error("value: expected %h, got %h",
                               owed_rsp.value, seen_rsp.value);
                        error_count++;
                    end
                    if (seen_rsp.index !== owed_rsp.index) begin
                        $error("index: expected %0d, got %0d",
                               owed_rsp.index, seen_rsp.index);
                        error_count++;
                    end
                    if (seen_rsp.count !== owed_rsp.count) begin
                        $error("count: expected %0d, got %0d",
                               owed_rsp.count, seen_rsp.count);
                        error_count++;
                    end
                end
            end
            if (req_if.valid && req_if.ready) begin
                model_rsp = apply_request(req_if.payload);
                taken_row = offered_rows.pop_front();
                awaited_rsps.push_back(taken_row.has_answer ? taken_row.want
                                                            : model_rsp);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        i_rst_n        = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_wdata    = 1'b0;
        req_if.valid   = 1'b0;
        req_if.payload = '0;

        // Ascending order throughout the table. The list starts empty.
        table_rows = '{
            '{req_of(skl_pkg::OP_POP_FRONT, 32'h0, 0, 0), 1'b1,
              rsp_of(skl_pkg::STAT_EMPTY, 32'h0, 0, 0)},
            '{req_of(skl_pkg::OP_POP_BACK, 32'h0, 0, 0), 1'b1,
              rsp_of(skl_pkg::STAT_EMPTY, 32'h0, 0, 0)},
            '{req_of(skl_pkg::OP_READ_AT, 32'h0, 0, 0), 1'b1,
              rsp_of(skl_pkg::STAT_EMPTY, 32'h0, 0, 0)},
            // An empty list wins over a bad position.
            '{req_of(skl_pkg::OP_REMOVE_AT, 32'h0, 16, 0), 1'b1,
              rsp_of(skl_pkg::STAT_EMPTY, 32'h0, 0, 0)},
            // Range end beyond the count.
            '{req_of(skl_pkg::OP_FIND, 32'h5, 0, 1), 1'b1,
              rsp_of(skl_pkg::STAT_BAD_POS, 32'h0, 0, 0)},
            // An empty range misses and reports its end.
            '{req_of(skl_pkg::OP_FIND, 32'h0, 0, 0), 1'b1,
              rsp_of(skl_pkg::STAT_NOT_FOUND, 32'h0, 0, 0)},
            '{req_of(skl_pkg::OP_INSERT, 32'h0, 0, 0), 1'b1,
              rsp_of(skl_pkg::STAT_OK, 32'h0, 0, 1)},
            '{req_of(skl_pkg::OP_INSERT, 32'hFFFF_FFFF, 0, 0), 1'b1,
              rsp_of(skl_pkg::STAT_OK, 32'hFFFF_FFFF, 1, 2)},
            '{req_of(skl_pkg::OP_INSERT, 32'h8000_0000, 0, 0), 1'b1,
              rsp_of(skl_pkg::STAT_OK, 32'h8000_0000, 1, 3)},
            // Equal key goes ahead of the one already stored.
            '{req_of(skl_pkg::OP_INSERT, 32'h8000_0000, 0, 0), 1'b0, '0},
            '{req_of(skl_pkg::OP_INSERT, 32'h7FFF_FFFF, 0, 0), 1'b0, '0},
            '{req_of(skl_pkg::OP_FIND, 32'h8000_0000, 0, 5), 1'b0, '0},
            '{req_of(skl_pkg::OP_FIND, 32'h8000_0000, 3, 5), 1'b0, '0},
            '{req_of(skl_pkg::OP_FIND, 32'h0001_2345, 0, 5), 1'b0, '0},
            '{req_of(skl_pkg::OP_FIND, 32'hFFFF_FFFF, 5, 5), 1'b0, '0},
            '{req_of(skl_pkg::OP_READ_AT, 32'h0, 4, 0), 1'b0, '0},
            '{req_of(skl_pkg::OP_READ_AT, 32'h0, 5, 0), 1'b1,
              rsp_of(skl_pkg::STAT_BAD_POS, 32'h0, 0, 5)},
            // Start of range above its end.
            '{req_of(skl_pkg::OP_FIND, 32'h0, 3, 2), 1'b1,
              rsp_of(skl_pkg::STAT_BAD_POS, 32'h0, 0, 5)},
            '{req_of(skl_pkg::OP_FIND, 32'h0, 0, 16), 1'b1,
              rsp_of(skl_pkg::STAT_BAD_POS, 32'h0, 0, 5)},
            '{req_of(skl_pkg::OP_REMOVE_AT, 32'h0, 1, 0), 1'b0, '0},
            '{req_of(skl_pkg::OP_REMOVE_AT, 32'h0, 3, 0), 1'b0, '0},
            '{req_of(skl_pkg::OP_POP_BACK, 32'h0, 0, 0), 1'b0, '0},
            '{req_of(skl_pkg::OP_POP_FRONT, 32'h0, 0, 0), 1'b0, '0}
        };

        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        write_order(1'b0);

        foreach (table_rows[i])
            offer(table_rows[i]);
        wait_until_drained();

        // Descending order, balanced mix.
        write_order(1'b1);
        random_phase(500, 50);
        wait_until_drained();

        // Ascending order: a stretch with no gaps on either side, then a
        // long response stall while requests keep coming.
        write_order(1'b0);
        no_gaps = 1'b1;
        random_phase(150, 50);
        no_gaps = 1'b0;
        random_phase(200, 50);
        sink_hold_cycles = 150;
        random_phase(300, 50);
        wait_until_drained();

        // Descending with mostly inserts, so the list sits at full.
        write_order(1'b1);
        random_phase(400, 75);
        wait_until_drained();

        // Ascending with mostly removals, so the list sits at empty.
        write_order(1'b0);
        random_phase(300, 30);
        wait_until_drained();

        // Any stray response in this window is still caught.
        repeat (20) @(negedge i_clk);
        if (error_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        #400000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
`default_nettype wire
